// File: sv/char_lcd_nibble_sequencer_top_assert.svh
// Assertion macros used by the sequencer's top-level RTL
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_TOP_ASSERT_SVH

// Check that a condition implies another condition in the same cycle
`define CLNS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed in the same cycle");

// Check that a condition implies another condition in the next cycle
`define CLNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed in the next cycle");

`endif

// File: sv/clns_pkg.sv
package clns_pkg;

   // Request kinds
   localparam logic [1:0] KIND_INIT   = 2'd0;
   localparam logic [1:0] KIND_INSTR  = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_CURSOR = 2'd3;

   // Register select codes
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // Sequence constants
   localparam logic [7:0] IDLE_WAIT_MS     = 8'd15;
   localparam logic [7:0] BYTE_WAIT_RESET  = 8'd2;
   localparam logic [4:0] MAX_COLUMN       = 5'd20;
   localparam logic [2:0] MAX_ROW          = 3'd4;
   localparam logic [4:0] LAST_WAKE_STEP   = 5'd4;
   localparam logic [4:0] FIRST_CMD_STEP   = 5'd5;
   localparam logic [4:0] LAST_INIT_STEP   = 5'd16;
   localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
   localparam logic [3:0] WAKE_NIBBLE_LAST = 4'h2;
   localparam logic [7:0] WAKE_WAIT_LONG   = 8'd5;
   localparam logic [7:0] WAKE_WAIT_SHORT  = 8'd1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [2:0] row;
      logic [4:0] column;
   } req_type;

   typedef struct packed {
      logic       strobe_res;
      logic       reg_select;
      logic [3:0] nibble;
      logic [7:0] wait_ms;
      logic       last;
   } step_type;

   // Command bytes sent after the wake-up pulses
   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      case (idx)
         3'd0: cmd = 8'h28;
         3'd1: cmd = 8'h08;
         3'd2: cmd = 8'h0C;
         3'd3: cmd = 8'h06;
         3'd4: cmd = 8'h02;
         3'd5: cmd = 8'h01;
         default: cmd = 8'h01;
      endcase
      return cmd;
   endfunction

   // DDRAM base address for rows one to four
   function automatic logic [7:0] row_base(input logic [1:0] row_idx);
      logic [7:0] base;
      case (row_idx)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h94;
         2'd3: base = 8'hD4;
         default: base = 8'h80;
      endcase
      return base;
   endfunction

endpackage

// File: sv/clns_req_if.sv
interface clns_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic [2:0] row;
   logic [4:0] column;

   modport source (output valid, output kind, output byte_value, output row,
                   output column, input ready);
   modport sink (input valid, input kind, input byte_value, input row,
                 input column, output ready);
endinterface

// File: sv/clns_rsp_if.sv
interface clns_rsp_if;
   logic       valid;
   logic       ready;
   logic       strobe_res;
   logic       reg_select;
   logic [3:0] nibble;
   logic [7:0] wait_ms;
   logic       last;

   modport source (output valid, output strobe_res, output reg_select, output nibble,
                   output wait_ms, output last, input ready);
   modport sink (input valid, input strobe_res, input reg_select, input nibble,
                 input wait_ms, input last, output ready);
endinterface

// File: sv/clns_step_gen.sv
module clns_step_gen (
   input  clns_pkg::req_type  req,
   input  logic [4:0]         step_idx,
   input  logic [7:0]         byte_wait,
   output clns_pkg::step_type step
);

   logic [7:0] send_byte;
   logic [4:0] cmd_off;
   logic [7:0] cmd_byte;
   logic       hi_half;

   // Pick the byte for single-byte requests
   always_comb begin
      send_byte = req.byte_value;
      if (req.kind == clns_pkg::KIND_CURSOR) begin
         send_byte = clns_pkg::row_base(req.row[1:0] - 2'd1)
                   + {3'b000, req.column} - 8'd1;
      end
   end

   // Locate the command byte inside the init sequence
   always_comb begin
      cmd_off  = step_idx - clns_pkg::FIRST_CMD_STEP;
      cmd_byte = clns_pkg::init_cmd(cmd_off[3:1]);
      hi_half  = ~cmd_off[0];
   end

   // Build the step
   always_comb begin
      step.strobe_res = 1'b1;
      step.reg_select = (req.kind == clns_pkg::KIND_DATA) ? clns_pkg::RS_DATA
                                                          : clns_pkg::RS_INSTR;
      step.nibble     = step_idx[0] ? send_byte[3:0] : send_byte[7:4];
      step.wait_ms    = step_idx[0] ? byte_wait : 8'd0;
      step.last       = step_idx[0];
      if (req.kind == clns_pkg::KIND_INIT) begin
         step.last = (step_idx == clns_pkg::LAST_INIT_STEP);
         if (step_idx == 5'd0) begin
            step.strobe_res = 1'b0;
            step.nibble     = 4'h0;
            step.wait_ms    = clns_pkg::IDLE_WAIT_MS;
         end else if (step_idx <= clns_pkg::LAST_WAKE_STEP) begin
            step.nibble  = (step_idx == clns_pkg::LAST_WAKE_STEP) ? clns_pkg::WAKE_NIBBLE_LAST
                                                                  : clns_pkg::WAKE_NIBBLE;
            step.wait_ms = step_idx[0] ? clns_pkg::WAKE_WAIT_LONG : clns_pkg::WAKE_WAIT_SHORT;
         end else begin
            step.nibble  = hi_half ? cmd_byte[7:4] : cmd_byte[3:0];
            step.wait_ms = hi_half ? 8'd0 : byte_wait;
         end
      end
   end

endmodule

// File: sv/clns_out_stage.sv
module clns_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  clns_pkg::step_type step,
   output logic               free,
   clns_rsp_if.source         rsp_if
);

   logic               valid_ff;
   logic               valid_in;
   clns_pkg::step_type data_ff;
   clns_pkg::step_type data_in;

   // Take a new step when empty or when the held one transfers
   assign free = ~valid_ff | rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = step;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.strobe_res = data_ff.strobe_res;
   assign rsp_if.reg_select = data_ff.reg_select;
   assign rsp_if.nibble     = data_ff.nibble;
   assign rsp_if.wait_ms    = data_ff.wait_ms;
   assign rsp_if.last       = data_ff.last;

endmodule

// File: sv/char_lcd_nibble_sequencer_top.sv
// Four-bit character LCD step sequencer. Each request becomes a run of steps, one step a
// cycle while rsp_if.ready is high: instruction, data and set-cursor requests give two
// steps (high then low nibble), init gives seventeen, and a set-cursor with a row outside
// 1..4 or a column outside 1..20 is accepted and gives nothing. The request register walks
// its step counter through the step generator into one output register, so the rate is
// one step per cycle while rsp_if.ready is high; the next request is taken in the cycle the
// current request's last step enters the output register. byte_wait_ff resets to 2; the
// user must write it through csr_wr_en/csr_wr_data only while idle; the block does not enforce this.
`include "char_lcd_nibble_sequencer_top_assert.svh"

module char_lcd_nibble_sequencer_top (
   input  logic       clock,
   input  logic       reset,
   clns_req_if.sink   req_if,
   clns_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]         byte_wait_ff;
   logic [7:0]         byte_wait_in;
   logic               busy_ff;
   logic               busy_in;
   logic [4:0]         step_ff;
   logic [4:0]         step_in;
   clns_pkg::req_type  req_ff;
   clns_pkg::req_type  req_in;
   clns_pkg::step_type step;
   logic               out_free;
   logic               step_load;
   logic               req_accept;
   logic               cursor_ok;
   logic               req_keep;
   logic               byte_req_busy;

   // Configuration register
   always_comb begin
      byte_wait_in = byte_wait_ff;
      if (csr_wr_en) begin
         byte_wait_in = csr_wr_data;
      end
   end

   // Current step of the active request
   clns_step_gen u_step_gen (
      .req       (req_ff),
      .step_idx  (step_ff),
      .byte_wait (byte_wait_ff),
      .step      (step)
   );

   clns_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (step_load),
      .step   (step),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

   assign step_load    = busy_ff & out_free;
   assign req_if.ready = ~busy_ff | (step_load & step.last);
   assign req_accept   = req_if.valid & req_if.ready;

   // Drop set-cursor requests outside the display
   assign cursor_ok = (req_if.row != 3'd0) && (req_if.row <= clns_pkg::MAX_ROW)
                   && (req_if.column != 5'd0) && (req_if.column <= clns_pkg::MAX_COLUMN);
   assign req_keep  = (req_if.kind != clns_pkg::KIND_CURSOR) | cursor_ok;

   // Advance through the steps, load the next request on transfer
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      req_in  = req_ff;
      if (step_load) begin
         if (step.last) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 5'd1;
         end
      end
      if (req_accept && req_keep) begin
         busy_in           = 1'b1;
         step_in           = 5'd0;
         req_in.kind       = req_if.kind;
         req_in.byte_value = req_if.byte_value;
         req_in.row        = req_if.row;
         req_in.column     = req_if.column;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_wait_ff <= clns_pkg::BYTE_WAIT_RESET;
         busy_ff      <= 1'b0;
         step_ff      <= 5'd0;
      end else begin
         byte_wait_ff <= byte_wait_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // A byte request in progress
   assign byte_req_busy = busy_ff && (req_ff.kind != clns_pkg::KIND_INIT);

   // Sequence checks
   `CLNS_ASSERT_SAME(a_step_range, clock, reset, busy_ff, step_ff <= clns_pkg::LAST_INIT_STEP)
   `CLNS_ASSERT_SAME(a_byte_two_steps, clock, reset, byte_req_busy, step_ff <= 5'd1)
   `CLNS_ASSERT_SAME(a_accept_on_last, clock, reset, req_accept && busy_ff, step_load && step.last)
   `CLNS_ASSERT_NEXT(a_load_shows, clock, reset, step_load, rsp_if.valid)

endmodule
